// ----- rtl/box_blur_3x3_rgb_top_assert.svh -----
// assertion macros for the 3x3 box blur
`ifndef BOX_BLUR_3X3_RGB_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define BB3_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define BB3_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define BB3_ASSERT_ALWAYS(lbl, cond, msg)

`define BB3_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/bb3_pkg.sv -----
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W = 24;
    localparam int ROW_W = 12;
    localparam int COL_W = 10;

    localparam int FW_W = 11;
    localparam int FH_W = 13;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd512;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd512;

    // register indexes, decoded from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // floor(x / 9) = (x * 7282) >> 16 for x up to 9 * 255
    localparam logic [12:0] DIV9_MULT  = 13'd7282;
    localparam int          DIV9_SHIFT = 16;

    typedef struct packed {
        logic                 interior;
        logic                 border;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [PIX_W-1:0]     pixel;
    } bb3_item_t;

endpackage

// ----- rtl/bb3_line_store.sv -----
module bb3_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bb3_lane.sv -----
module bb3_lane (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       advance,
    input  logic [7:0] upper,
    input  logic [7:0] middle,
    input  logic [7:0] cur,
    output logic [7:0] quotient
);

    import bb3_pkg::*;

    // column sums of the two previous window columns
    logic [9:0]  cs0_reg;
    logic [9:0]  cs1_reg;
    logic [11:0] sum_reg;

    logic [9:0]  cs_cur;
    logic [11:0] sum_next;
    logic [24:0] prod;

    assign cs_cur   = 10'(upper) + 10'(middle) + 10'(cur);
    assign sum_next = 12'(cs0_reg) + 12'(cs1_reg) + 12'(cs_cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs0_reg <= '0;
            cs1_reg <= '0;
        end
        else if (clear)
        begin
            cs0_reg <= '0;
            cs1_reg <= '0;
        end
        else if (advance)
        begin
            cs0_reg <= cs1_reg;
            cs1_reg <= cs_cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg <= sum_next;
        end
    end

    // divide by nine through the reciprocal
    assign prod     = 25'(sum_reg) * 25'(DIV9_MULT);
    assign quotient = prod[DIV9_SHIFT +: 8];

endmodule

// ----- rtl/bb3_merge.sv -----
module bb3_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bb3_pkg::bb3_item_t item,
    input  logic [7:0]        red_q,
    input  logic [7:0]        green_q,
    input  logic [7:0]        blue_q,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,
    output logic              m_tlast
);

    import bb3_pkg::*;

    logic             s2_valid_reg;
    logic             int_pend_reg;
    logic             bord_pend_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [PIX_W-1:0] pix_reg;

    logic             out_valid_reg;
    logic [47:0]      out_data_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             emit;
    logic             last_emit;
    logic             done;
    logic [47:0]      out_data_next;
    logic             out_last_next;

    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = s2_valid_reg && out_free && (int_pend_reg || bord_pend_reg);
    assign last_emit = emit && !(int_pend_reg && bord_pend_reg);
    assign done      = s2_valid_reg && (!(int_pend_reg || bord_pend_reg) || last_emit);
    assign free      = !s2_valid_reg || done;

    // interior result for the window center first, then the border pixel
    always_comb
    begin
        if (int_pend_reg)
        begin
            out_data_next = {2'b00, blue_q, green_q, red_q,
                             col_reg - 10'd1, row_reg - 12'd1};
            out_last_next = !bord_pend_reg;
        end
        else
        begin
            out_data_next = {2'b00, pix_reg[7:0], pix_reg[15:8], pix_reg[23:16],
                             col_reg, row_reg};
            out_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            int_pend_reg  <= 1'b0;
            bord_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s2_valid_reg  <= 1'b1;
                int_pend_reg  <= item.interior;
                bord_pend_reg <= item.border;
            end
            else if (done)
            begin
                s2_valid_reg  <= 1'b0;
                int_pend_reg  <= 1'b0;
                bord_pend_reg <= 1'b0;
            end
            else if (emit)
            begin
                int_pend_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= item.row;
            col_reg <= item.col;
            pix_reg <= item.pixel;
        end
        if (emit)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/box_blur_3x3_rgb_top.sv -----
// path: input stage register, lane sums and merge stage, output register; throughput: one
// pixel per cycle while the output accepts; pixels that yield two results (last column from
// row 2 on, last row from column 2 on) hold input until the single output register takes both
// reset: position counters and window clear, both size registers return to 512,
// line stores keep their contents and need no clearing pass
module box_blur_3x3_rgb_top #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_row, out_column, red_out, green_out, blue_out, pad
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import bb3_pkg::*;

    `include "box_blur_3x3_rgb_top_assert.svh"

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [CW-1:0]    last_col;
    logic [ROW_W-1:0] last_row;
    logic [31:0]      width_eff;

    logic [CW-1:0]    col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;

    logic             s1_valid_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [PIX_W-1:0] s1_pix_reg;

    logic             cfg_wr;
    logic             accept;
    logic             s1_adv;
    logic             s2_free;
    logic [PIX_W-1:0] pixel_in;
    logic [47:0]      rd_data;
    logic [CW+9:0]    col_wide;
    bb3_item_t        item;

    logic [7:0]       red_q;
    logic [7:0]       green_q;
    logic [7:0]       blue_q;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // clamp the frame size to the supported range
    always_comb
    begin
        if (32'(frame_width_reg) < 32'd3)
        begin
            width_eff = 32'd3;
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            width_eff = 32'(MAX_WIDTH);
        end
        else
        begin
            width_eff = 32'(frame_width_reg);
        end
        last_col = CW'(width_eff - 32'd1);

        if (frame_height_reg < 13'd3)
        begin
            last_row = 12'd2;
        end
        else if (frame_height_reg > 13'(MAX_HEIGHT))
        begin
            last_row = 12'(MAX_HEIGHT - 1);
        end
        else
        begin
            last_row = 12'(frame_height_reg - 13'd1);
        end
    end

    assign s_axis_tready = !s1_valid_reg || s2_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_adv        = s1_valid_reg && s2_free;
    assign pixel_in      = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                if (col_cnt_reg == last_col)
                begin
                    col_cnt_reg <= '0;
                    if (row_cnt_reg == last_row)
                    begin
                        row_cnt_reg <= '0;
                    end
                    else
                    begin
                        row_cnt_reg <= row_cnt_reg + 12'd1;
                    end
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= col_cnt_reg;
            s1_row_reg <= row_cnt_reg;
            s1_pix_reg <= pixel_in;
        end
    end

    // upper row in the high half, middle row in the low half
    bb3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (2 * PIX_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({rd_data[PIX_W-1:0], s1_pix_reg})
    );

    bb3_lane u_lane_red (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_wr),
        .advance  (s1_adv),
        .upper    (rd_data[47:40]),
        .middle   (rd_data[23:16]),
        .cur      (s1_pix_reg[23:16]),
        .quotient (red_q)
    );

    bb3_lane u_lane_green (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_wr),
        .advance  (s1_adv),
        .upper    (rd_data[39:32]),
        .middle   (rd_data[15:8]),
        .cur      (s1_pix_reg[15:8]),
        .quotient (green_q)
    );

    bb3_lane u_lane_blue (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_wr),
        .advance  (s1_adv),
        .upper    (rd_data[31:24]),
        .middle   (rd_data[7:0]),
        .cur      (s1_pix_reg[7:0]),
        .quotient (blue_q)
    );

    assign col_wide = {10'd0, s1_col_reg};

    always_comb
    begin
        item.interior = (s1_row_reg >= 12'd2) && (s1_row_reg <= last_row) &&
                        (s1_col_reg >= CW'(2)) && (s1_col_reg <= last_col);
        item.border   = (s1_row_reg == 12'd0) || (s1_row_reg >= last_row) ||
                        (s1_col_reg == CW'(0)) || (s1_col_reg >= last_col);
        item.row      = s1_row_reg;
        item.col      = col_wide[COL_W-1:0];
        item.pixel    = s1_pix_reg;
    end

    bb3_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_adv),
        .item     (item),
        .red_q    (red_q),
        .green_q  (green_q),
        .blue_q   (blue_q),
        .free     (s2_free),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast)
    );

    `BB3_ASSERT_ALWAYS(a_col_in_frame, col_cnt_reg <= last_col, "column counter beyond frame")
    `BB3_ASSERT_ALWAYS(a_row_in_frame, row_cnt_reg <= last_row, "row counter beyond frame")
    `BB3_ASSERT_IMPLY(a_no_rw_clash, accept && s1_adv, col_cnt_reg != s1_col_reg, "line store read and write hit one column")

endmodule

// ----- dv/blur_checker.sv -----
module blur_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // out_row, out_column, red_out, green_out, blue_out, pad
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          outstanding,
    output int          errors,
    output int          results_seen
);

    import bb3_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic [1:0]       pad;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } result_word_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        rgb_t             px;
        logic             last;
    } blur_result_t;

    rgb_t            upper_line [MAX_WIDTH_DEF];
    rgb_t            middle_line [MAX_WIDTH_DEF];
    rgb_t            window_px [2][3];
    int unsigned     row_pos;
    int unsigned     col_pos;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    blur_result_t    expected_px [$];
    int              fail_count = 0;
    int              result_count = 0;

    initial
    begin
        foreach (upper_line[i])
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic restart_frame();
        row_pos = 0;
        col_pos = 0;
        foreach (window_px[k, j])
            window_px[k][j] = '0;
    endtask

    task automatic predict_blur(input rgb_t px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  sum_r;
        int unsigned  sum_g;
        int unsigned  sum_b;
        rgb_t         stack [3];
        blur_result_t res;
        bit           produced;
        w = 32'(width_reg);
        if (w < 3)
            w = 3;
        if (w > MAX_WIDTH_DEF)
            w = MAX_WIDTH_DEF;
        h = 32'(height_reg);
        if (h < 3)
            h = 3;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        stack[0] = upper_line[col_pos];
        stack[1] = middle_line[col_pos];
        stack[2] = px;
        produced = 1'b0;

        // interior pixel one row up and one column left is now complete
        if (row_pos >= 2 && row_pos <= h - 1 && col_pos >= 2 && col_pos <= w - 1)
        begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int j = 0; j < 3; j++)
            begin
                sum_r += window_px[0][j].red + window_px[1][j].red + stack[j].red;
                sum_g += window_px[0][j].green + window_px[1][j].green + stack[j].green;
                sum_b += window_px[0][j].blue + window_px[1][j].blue + stack[j].blue;
            end
            res.row      = 12'(row_pos - 1);
            res.column   = 10'(col_pos - 1);
            res.px.red   = 8'(sum_r / 9);
            res.px.green = 8'(sum_g / 9);
            res.px.blue  = 8'(sum_b / 9);
            res.last     = 1'b0;
            expected_px.push_back(res);
            produced = 1'b1;
        end

        // border pixels pass through
        if (row_pos == 0 || row_pos >= h - 1 || col_pos == 0 || col_pos >= w - 1)
        begin
            res.row    = 12'(row_pos);
            res.column = 10'(col_pos);
            res.px     = px;
            res.last   = 1'b0;
            expected_px.push_back(res);
            produced = 1'b1;
        end

        if (produced)
            expected_px[expected_px.size() - 1].last = 1'b1;

        for (int k = 0; k < 3; k++)
        begin
            window_px[0][k] = window_px[1][k];
            window_px[1][k] = stack[k];
        end
        upper_line[col_pos]  = stack[1];
        middle_line[col_pos] = px;

        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_word_t got;
        blur_result_t want;
        if (!rst_n)
        begin
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            restart_frame();
            expected_px.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                result_count++;
                if (expected_px.size() == 0)
                begin
                    $error("result at row %0d column %0d with nothing expected",
                           got.row, got.column);
                    fail_count++;
                end
                else
                begin
                    want = expected_px.pop_front();
                    check_field("out_row", 32'(want.row), 32'(got.row));
                    check_field("out_column", 32'(want.column), 32'(got.column));
                    check_field("red_out", 32'(want.px.red), 32'(got.red));
                    check_field("green_out", 32'(want.px.green), 32'(got.green));
                    check_field("blue_out", 32'(want.px.blue), 32'(got.blue));
                    check_field("last_of_run", 32'(want.last), 32'(m_axis_tlast));
                end
            end

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_FRAME_WIDTH)
                        width_reg = pwdata[FW_W-1:0];
                    else
                        height_reg = pwdata[FH_W-1:0];
                    restart_frame();
                end
                else if (paddr[2] == REG_FRAME_WIDTH)
                    check_field("frame_width", 32'(width_reg), prdata);
                else
                    check_field("frame_height", 32'(height_reg), prdata);
            end

            if (s_axis_tvalid && s_axis_tready)
                predict_blur(s_axis_tdata);
        end
        outstanding  <= expected_px.size();
        errors       <= fail_count;
        results_seen <= result_count;
    end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    import bb3_pkg::*;

    localparam logic [2:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 450;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // red_in, green_in, blue_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // out_row, out_column, red_out, green_out, blue_out, pad
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int   outstanding;
    int   errors;
    int   results_seen;
    logic steady = 1'b0;
    logic stall_kick = 1'b0;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   eff_w;
    int   eff_h;
    int   pixels_sent = 0;
    int   settings_count = 0;

    box_blur_3x3_rgb_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    blur_checker blur_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .outstanding   (outstanding),
        .errors        (errors),
        .results_seen  (results_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("box_blur_3x3_rgb_top test failed");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_kick)
        begin
            stall_left    <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady || ($urandom_range(99) >= 12);
    end

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [7:0] pick_channel();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 8'h00;
        if (roll < 20)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_pixel(input logic [23:0] px);
        if (!steady && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_frame_reg(input logic [2:0] addr, input logic [31:0] value);
        apb_access(1'b1, addr, value);
        apb_access(1'b0, addr, '0);
    endtask

    task automatic program_frame(input logic [10:0] w, input logic [12:0] h, input bit both);
        int pick;
        pick = both ? 5 : $urandom_range(9);
        if (pick == 0)
            write_frame_reg(ADDR_FRAME_WIDTH, 32'(w));
        else if (pick == 1)
            write_frame_reg(ADDR_FRAME_HEIGHT, 32'(h));
        else if (pick < 6)
        begin
            write_frame_reg(ADDR_FRAME_WIDTH, 32'(w));
            write_frame_reg(ADDR_FRAME_HEIGHT, 32'(h));
        end
        else
        begin
            write_frame_reg(ADDR_FRAME_HEIGHT, 32'(h));
            write_frame_reg(ADDR_FRAME_WIDTH, 32'(w));
        end
        if (pick != 1)
            eff_w = clamp(32'(w), 3, MAX_WIDTH_DEF);
        if (pick != 0)
            eff_h = clamp(32'(h), 3, MAX_HEIGHT);
        settings_count++;
    endtask

    task automatic send_frames(input int count, input bit pause_midway);
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                drain();
            send_pixel({pick_channel(), pick_channel(), pick_channel()});
        end
    endtask

    initial
    begin : stimulus
        int          frame_px;
        int          count;
        int          roll;
        int          phase;
        int          random_start;
        logic [10:0] wv;
        logic [12:0] hv;
        eff_w = 32'(FRAME_WIDTH_RST);
        eff_h = 32'(FRAME_HEIGHT_RST);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes, then a few top-row pixels at the default width
        apb_access(1'b0, ADDR_FRAME_WIDTH, '0);
        apb_access(1'b0, ADDR_FRAME_HEIGHT, '0);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF00FF);
        drain();

        // undersized registers clamp to 3x3: saturated frame, then a mixed one
        program_frame(11'd0, 13'd2, 1'b1);
        repeat (9) send_pixel(24'hFFFFFF);
        for (int i = 0; i < 9; i++)
            send_pixel({8'(i * 29), 8'(255 - i * 17), (i % 2 == 1) ? 8'hFF : 8'h00});
        drain();

        phase = 0;
        random_start = pixels_sent;
        while ((pixels_sent - random_start < RANDOM_PIXELS) || (phase < 4))
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                wv = 11'($urandom_range(3, 10));
            else if (roll < 80)
                wv = 11'($urandom_range(0, 2));
            else if (roll < 90)
                wv = 11'($urandom_range(11, 40));
            else
                wv = 11'($urandom_range(41, 64));
            roll = $urandom_range(99);
            if (roll < 65)
                hv = 13'($urandom_range(3, 8));
            else if (roll < 80)
                hv = 13'($urandom_range(0, 2));
            else if (roll < 90)
                hv = 13'(MAX_HEIGHT);
            else
                hv = 13'($urandom_range(MAX_HEIGHT + 1, 8191));
            program_frame(wv, hv, 1'b0);

            // frames or runs of rows, sometimes ending mid-frame so the next write restarts it
            frame_px = eff_w * eff_h;
            if (frame_px <= 400)
                count = frame_px * $urandom_range(1, 2) +
                        (($urandom_range(3) == 0) ? $urandom_range(1, frame_px - 1) : 0);
            else
                count = eff_w * $urandom_range(3, 8) + $urandom_range(0, eff_w - 1);

            steady <= ($urandom_range(3) == 0);
            if (phase == 1)
            begin
                stall_kick <= 1'b1;
                @(posedge clk);
                stall_kick <= 1'b0;
            end
            send_frames(count, phase == 3);
            drain();
            phase++;
        end

        // widest frame, no idling on either side
        program_frame(11'h7FF, 13'd3, 1'b1);
        steady <= 1'b1;
        send_frames(MAX_WIDTH_DEF + 4, 1'b0);
        drain();
        steady <= 1'b0;
        repeat (10) @(posedge clk);

        $display("covered %0d pixels over %0d frame sizes (clamped, wrapped, restarted),",
                 pixels_sent, settings_count);
        $display("%0d filtered and border results compared", results_seen);
        if (errors == 0)
            $display("box_blur_3x3_rgb_top test passed");
        else
            $display("box_blur_3x3_rgb_top test failed");
        $finish;
    end

endmodule
